/* hdl/dpsd_pkg.sv */
// Shared types, constants and the CRC-16/XMODEM byte update for the deframer.
`timescale 1ns / 1ps
`default_nettype none

package dpsd_pkg;

  // Largest MSP payload held; larger size bytes drop the frame.
  localparam logic [7:0] MSP_BUF_BYTES = 8'd192;

  // Opcodes on the input channel
  localparam logic [1:0] OP_DATA      = 2'd0;
  localparam logic [1:0] OP_FORCE_FW  = 2'd1;
  localparam logic [1:0] OP_FORCE_MSP = 2'd2;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [8:0]  FW_LEN_ZERO = 9'd256;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_START,
    MP_M,
    MP_ARROW,
    MP_SIZE,
    MP_BODY
  } msp_phase_e;

  typedef enum logic [2:0] {
    FP_IDLE,
    FP_START,
    FP_CMD,
    FP_AHI,
    FP_ALO,
    FP_BODY,
    FP_CRC1,
    FP_CRC2
  } fw_phase_e;

  typedef struct packed {
    logic        four_way;
    msp_phase_e  msp_phase;
    logic        msp_is_command;
    logic [7:0]  msp_length;
    logic [7:0]  msp_count;
    logic [7:0]  msp_xor;
    logic [7:0]  msp_command;
    fw_phase_e   fw_phase;
    logic [7:0]  fw_command;
    logic [15:0] fw_address;
    logic [8:0]  fw_length;
    logic [8:0]  fw_count;
    logic [15:0] fw_crc;
    logic [7:0]  fw_crc_high;
  } state_t;

  localparam state_t STATE_RESET = '{
    four_way:       1'b0,
    msp_phase:      MP_IDLE,
    msp_is_command: 1'b0,
    msp_length:     8'd0,
    msp_count:      8'd0,
    msp_xor:        8'd0,
    msp_command:    8'd0,
    fw_phase:       FP_IDLE,
    fw_command:     8'd0,
    fw_address:     16'd0,
    fw_length:      9'd0,
    fw_count:       9'd0,
    fw_crc:         16'd0,
    fw_crc_high:    8'd0
  };

  typedef struct packed {
    logic        consumed;
    logic        frame_valid;
    logic        check_failed;
    logic        protocol;
    logic        payload_strobe;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [15:0] address;
    logic [8:0]  payload_len;
  } result_t;

  // One byte through CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] c);
    logic [15:0] v;
    v = crc ^ {c, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/dpsd_step.sv */
// Per-word next-state and result logic for both frame parsers.
`timescale 1ns / 1ps
`default_nettype none

module dpsd_step (
  input  wire logic [1:0]      opcode_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire dpsd_pkg::state_t cur_i,
  output dpsd_pkg::state_t     nxt_o,
  output dpsd_pkg::result_t    res_o
);

  logic mode;
  logic fw_good;
  logic [8:0] fw_count_inc;

  assign fw_count_inc = cur_i.fw_count + 9'd1;
  assign fw_good      = ({cur_i.fw_crc_high, data_byte_i} == cur_i.fw_crc);

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    mode  = cur_i.four_way;

    case (opcode_i)
      dpsd_pkg::OP_DATA: begin
        if (mode && cur_i.fw_phase == dpsd_pkg::FP_IDLE
            && data_byte_i == dpsd_pkg::CH_DOLLAR) begin
          mode = 1'b0;
        end
        if (!mode && cur_i.msp_phase == dpsd_pkg::MP_IDLE
            && data_byte_i == dpsd_pkg::CH_SLASH) begin
          mode = 1'b1;
        end
        res_o.consumed = 1'b1;

        if (mode) begin
          case (cur_i.fw_phase)
            dpsd_pkg::FP_START: begin
              nxt_o.fw_command = data_byte_i;
              nxt_o.fw_crc     = dpsd_pkg::crc_step(cur_i.fw_crc, data_byte_i);
              nxt_o.fw_phase   = dpsd_pkg::FP_CMD;
            end
            dpsd_pkg::FP_CMD: begin
              nxt_o.fw_address = {data_byte_i, 8'h00};
              nxt_o.fw_crc     = dpsd_pkg::crc_step(cur_i.fw_crc, data_byte_i);
              nxt_o.fw_phase   = dpsd_pkg::FP_AHI;
            end
            dpsd_pkg::FP_AHI: begin
              nxt_o.fw_address = {cur_i.fw_address[15:8], data_byte_i};
              nxt_o.fw_crc     = dpsd_pkg::crc_step(cur_i.fw_crc, data_byte_i);
              nxt_o.fw_phase   = dpsd_pkg::FP_ALO;
            end
            dpsd_pkg::FP_ALO: begin
              nxt_o.fw_length = (data_byte_i == 8'd0) ? dpsd_pkg::FW_LEN_ZERO
                                                      : {1'b0, data_byte_i};
              nxt_o.fw_count  = 9'd0;
              nxt_o.fw_crc    = dpsd_pkg::crc_step(cur_i.fw_crc, data_byte_i);
              nxt_o.fw_phase  = dpsd_pkg::FP_BODY;
            end
            dpsd_pkg::FP_BODY: begin
              res_o.payload_strobe = 1'b1;
              res_o.payload_index  = cur_i.fw_count[7:0];
              res_o.payload_byte   = data_byte_i;
              nxt_o.fw_crc         = dpsd_pkg::crc_step(cur_i.fw_crc, data_byte_i);
              nxt_o.fw_count       = fw_count_inc;
              if (fw_count_inc == cur_i.fw_length) begin
                nxt_o.fw_phase = dpsd_pkg::FP_CRC1;
              end
            end
            dpsd_pkg::FP_CRC1: begin
              nxt_o.fw_crc_high = data_byte_i;
              nxt_o.fw_phase    = dpsd_pkg::FP_CRC2;
            end
            dpsd_pkg::FP_CRC2: begin
              if (fw_good) begin
                res_o.frame_valid = 1'b1;
                nxt_o.msp_phase   = dpsd_pkg::MP_IDLE;
              end else begin
                res_o.check_failed = 1'b1;
              end
              nxt_o.fw_phase = dpsd_pkg::FP_IDLE;
            end
            default: begin
              nxt_o.fw_phase = dpsd_pkg::FP_IDLE;
              if (data_byte_i == dpsd_pkg::CH_SLASH) begin
                nxt_o.fw_phase = dpsd_pkg::FP_START;
                nxt_o.fw_crc   = dpsd_pkg::crc_step(16'h0000, data_byte_i);
              end else begin
                res_o.consumed = 1'b0;
              end
            end
          endcase
        end else begin
          case (cur_i.msp_phase)
            dpsd_pkg::MP_START: begin
              nxt_o.msp_phase = (data_byte_i == dpsd_pkg::CH_M) ? dpsd_pkg::MP_M
                                                                : dpsd_pkg::MP_IDLE;
            end
            dpsd_pkg::MP_M: begin
              if (data_byte_i == dpsd_pkg::CH_LT || data_byte_i == dpsd_pkg::CH_GT) begin
                nxt_o.msp_is_command = (data_byte_i == dpsd_pkg::CH_LT);
                nxt_o.msp_phase      = dpsd_pkg::MP_ARROW;
              end else begin
                nxt_o.msp_phase = dpsd_pkg::MP_IDLE;
              end
            end
            dpsd_pkg::MP_ARROW: begin
              if (data_byte_i > dpsd_pkg::MSP_BUF_BYTES) begin
                nxt_o.msp_phase = dpsd_pkg::MP_IDLE;
              end else begin
                nxt_o.msp_length = data_byte_i;
                nxt_o.msp_count  = 8'd0;
                nxt_o.msp_xor    = data_byte_i;
                nxt_o.msp_phase  = dpsd_pkg::MP_SIZE;
              end
            end
            dpsd_pkg::MP_SIZE: begin
              nxt_o.msp_command = data_byte_i;
              nxt_o.msp_xor     = cur_i.msp_xor ^ data_byte_i;
              nxt_o.msp_phase   = dpsd_pkg::MP_BODY;
            end
            dpsd_pkg::MP_BODY: begin
              if (cur_i.msp_count < cur_i.msp_length) begin
                nxt_o.msp_xor        = cur_i.msp_xor ^ data_byte_i;
                res_o.payload_strobe = 1'b1;
                res_o.payload_index  = cur_i.msp_count;
                res_o.payload_byte   = data_byte_i;
                nxt_o.msp_count      = cur_i.msp_count + 8'd1;
              end else begin
                if (cur_i.msp_xor == data_byte_i) begin
                  res_o.frame_valid = cur_i.msp_is_command;
                  nxt_o.fw_phase    = dpsd_pkg::FP_IDLE;
                end else begin
                  res_o.check_failed = 1'b1;
                end
                nxt_o.msp_phase = dpsd_pkg::MP_IDLE;
              end
            end
            default: begin
              nxt_o.msp_phase = dpsd_pkg::MP_IDLE;
              if (data_byte_i == dpsd_pkg::CH_DOLLAR) begin
                nxt_o.msp_phase = dpsd_pkg::MP_START;
              end else begin
                res_o.consumed = 1'b0;
              end
            end
          endcase
        end
      end
      dpsd_pkg::OP_FORCE_FW: begin
        mode = 1'b1;
      end
      dpsd_pkg::OP_FORCE_MSP: begin
        mode = 1'b0;
      end
      default: begin
        mode = cur_i.four_way;
      end
    endcase

    nxt_o.four_way = mode;
    res_o.protocol = mode;
    if (mode) begin
      res_o.command     = nxt_o.fw_command;
      res_o.address     = nxt_o.fw_address;
      res_o.payload_len = nxt_o.fw_length;
    end else begin
      res_o.command     = nxt_o.msp_command;
      res_o.address     = 16'd0;
      res_o.payload_len = {1'b0, nxt_o.msp_length};
    end
  end

endmodule

`default_nettype wire

/* hdl/dual_protocol_serial_deframer.sv */
// Top level: MSP v1 and four-way serial deframer with input and result registers.
//
// Input channel: one word per handshake (in_valid_i high, in_stall_o low),
// carrying an opcode and a received serial byte. Opcode 0 parses the byte,
// 1 forces four-way mode, 2 forces MSP mode; code 3 changes nothing.
// Output channel: exactly one result word per input word, in order, on
// out_valid_o, held while out_stall_i is high.
// Path: an accepted word waits in the input register and is parsed as it
// moves into the result register, from which its result is shown.
// Throughput: one word per cycle while the receiver does not stall; the parser state update is a single
// pass of byte-wide logic (XOR, compares, one unrolled CRC byte step).
// Reset: both parsers idle, MSP mode, all header fields zero, both
// registers empty.
// Stall: while the result register is full and stalled the input register
// holds its word and in_stall_o rises, so at most two words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module dual_protocol_serial_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  data_byte_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             consumed_o,
  output logic             frame_valid_o,
  output logic             check_failed_o,
  output logic             protocol_o,
  output logic             payload_strobe_o,
  output logic [7:0]       payload_index_o,
  output logic [7:0]       payload_byte_o,
  output logic [7:0]       command_o,
  output logic [15:0]      address_o,
  output logic [8:0]       payload_len_o
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] opcode_q;
  logic [7:0] byte_q;

  // Parser state and result register
  dpsd_pkg::state_t  state_q, state_d;
  dpsd_pkg::result_t res_q, res_d;
  logic              out_valid_q, out_valid_d;

  logic advance;
  logic in_take;

  // Move the held word into the result register whenever that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  dpsd_step u_step (
    .opcode_i    (opcode_q),
    .data_byte_i (byte_q),
    .cur_i       (state_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // Control: valid flags and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= dpsd_pkg::STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload: held word and finished result
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q <= opcode_i;
      byte_q   <= data_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign consumed_o       = res_q.consumed;
  assign frame_valid_o    = res_q.frame_valid;
  assign check_failed_o   = res_q.check_failed;
  assign protocol_o       = res_q.protocol;
  assign payload_strobe_o = res_q.payload_strobe;
  assign payload_index_o  = res_q.payload_index;
  assign payload_byte_o   = res_q.payload_byte;
  assign command_o        = res_q.command;
  assign address_o        = res_q.address;
  assign payload_len_o    = res_q.payload_len;

endmodule

`default_nettype wire

/* hdl/dpsd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dpsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        consumed_o,
  input wire logic        frame_valid_o,
  input wire logic        check_failed_o,
  input wire logic        protocol_o,
  input wire logic        payload_strobe_o,
  input wire logic [7:0]  payload_index_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic [15:0] address_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(frame_valid_o) && $stable(protocol_o))
    else $error("stalled result word changed");

  // A frame ends either good or bad, never both
  a_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_valid_o && check_failed_o))
    else $error("frame reported good and failed");

  // Strobes and frame ends only on bytes the parser took
  a_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !consumed_o |-> !payload_strobe_o && !frame_valid_o && !check_failed_o)
    else $error("event on an unconsumed byte");

  // Payload lanes read zero without a strobe; MSP mode shows no address
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_strobe_o |->
      payload_index_o == 8'd0 && payload_byte_o == 8'd0
      && (protocol_o || address_o == 16'd0))
    else $error("stale payload or address field");

endmodule

bind dual_protocol_serial_deframer dpsd_checker u_dpsd_checker (.*);

`default_nettype wire

/* bench/dual_protocol_serial_deframer_check.sv */
// Checker: watches both channels, predicts each result word and compares it field by field.
`timescale 1ns / 1ps

module dual_protocol_serial_deframer_check
  import dpsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        consumed_i,
  input  logic        frame_valid_i,
  input  logic        check_failed_i,
  input  logic        protocol_i,
  input  logic        payload_strobe_i,
  input  logic [7:0]  payload_index_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [8:0]  payload_len_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  // Parser state as the block should hold it
  logic        mode_fw;
  msp_phase_e  msp_st;
  logic        msp_cmd_frame;
  logic [7:0]  msp_len;
  logic [7:0]  msp_cnt;
  logic [7:0]  msp_sum;
  logic [7:0]  msp_cmd;
  fw_phase_e   fw_st;
  logic [7:0]  fw_cmd;
  logic [15:0] fw_addr;
  logic [8:0]  fw_len;
  logic [8:0]  fw_cnt;
  logic [15:0] fw_crc;
  logic [7:0]  fw_crc_hi;

  // Result words owed by the block, oldest first
  result_t parsed_q[$];

  // CRC-16/XMODEM, one data bit at a time, MSB first
  function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] c);
    logic        fb;
    logic [15:0] acc;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ c[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  task automatic take_msp_byte(input logic [7:0] c, inout result_t r);
    r.consumed = 1'b1;
    case (msp_st)
      MP_START: begin
        if (c == CH_M) msp_st = MP_M;
        else msp_st = MP_IDLE;
      end
      MP_M: begin
        if (c == CH_LT || c == CH_GT) begin
          msp_cmd_frame = (c == CH_LT);
          msp_st        = MP_ARROW;
        end else begin
          msp_st = MP_IDLE;
        end
      end
      MP_ARROW: begin
        // drop frames too long for the buffer
        if (c > MSP_BUF_BYTES) begin
          msp_st = MP_IDLE;
        end else begin
          msp_len = c;
          msp_cnt = 8'd0;
          msp_sum = c;
          msp_st  = MP_SIZE;
        end
      end
      MP_SIZE: begin
        msp_cmd = c;
        msp_sum ^= c;
        msp_st  = MP_BODY;
      end
      MP_BODY: begin
        if (msp_cnt < msp_len) begin
          msp_sum ^= c;
          r.payload_strobe = 1'b1;
          r.payload_index  = msp_cnt;
          r.payload_byte   = c;
          msp_cnt++;
        end else begin
          if (msp_sum == c) begin
            if (msp_cmd_frame) r.frame_valid = 1'b1;
            fw_st = FP_IDLE;
          end else begin
            r.check_failed = 1'b1;
          end
          msp_st = MP_IDLE;
        end
      end
      default: begin
        if (c == CH_DOLLAR) begin
          msp_st = MP_START;
        end else begin
          msp_st     = MP_IDLE;
          r.consumed = 1'b0;
        end
      end
    endcase
  endtask

  task automatic take_fw_byte(input logic [7:0] c, inout result_t r);
    r.consumed = 1'b1;
    case (fw_st)
      FP_START: begin
        fw_cmd = c;
        fw_crc = xmodem_update(fw_crc, c);
        fw_st  = FP_CMD;
      end
      FP_CMD: begin
        fw_addr = {c, 8'h00};
        fw_crc  = xmodem_update(fw_crc, c);
        fw_st   = FP_AHI;
      end
      FP_AHI: begin
        fw_addr[7:0] = c;
        fw_crc       = xmodem_update(fw_crc, c);
        fw_st        = FP_ALO;
      end
      FP_ALO: begin
        fw_len = (c == 8'd0) ? FW_LEN_ZERO : {1'b0, c};
        fw_cnt = 9'd0;
        fw_crc = xmodem_update(fw_crc, c);
        fw_st  = FP_BODY;
      end
      FP_BODY: begin
        r.payload_strobe = 1'b1;
        r.payload_index  = fw_cnt[7:0];
        r.payload_byte   = c;
        fw_crc = xmodem_update(fw_crc, c);
        fw_cnt++;
        if (fw_cnt == fw_len) fw_st = FP_CRC1;
      end
      FP_CRC1: begin
        fw_crc_hi = c;
        fw_st     = FP_CRC2;
      end
      FP_CRC2: begin
        if ({fw_crc_hi, c} == fw_crc) begin
          r.frame_valid = 1'b1;
          msp_st        = MP_IDLE;
        end else begin
          r.check_failed = 1'b1;
        end
        fw_st = FP_IDLE;
      end
      default: begin
        if (c == CH_SLASH) begin
          fw_st  = FP_START;
          fw_crc = xmodem_update(16'h0000, c);
        end else begin
          fw_st      = FP_IDLE;
          r.consumed = 1'b0;
        end
      end
    endcase
  endtask

  task automatic parse_word(input logic [1:0] op, input logic [7:0] c, output result_t r);
    r = '0;
    case (op)
      OP_FORCE_FW:  mode_fw = 1'b1;
      OP_FORCE_MSP: mode_fw = 1'b0;
      OP_DATA: begin
        if (mode_fw && fw_st == FP_IDLE && c == CH_DOLLAR) mode_fw = 1'b0;
        if (!mode_fw && msp_st == MP_IDLE && c == CH_SLASH) mode_fw = 1'b1;
        if (mode_fw) take_fw_byte(c, r);
        else take_msp_byte(c, r);
      end
      default: ;
    endcase
    r.protocol = mode_fw;
    if (mode_fw) begin
      r.command     = fw_cmd;
      r.address     = fw_addr;
      r.payload_len = fw_len;
    end else begin
      r.command     = msp_cmd;
      r.address     = 16'h0000;
      r.payload_len = {1'b0, msp_len};
    end
  endtask

  function automatic int field_bad(input string name, input logic [15:0] want_v,
                                   input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      mode_fw       = 1'b0;
      msp_st        = MP_IDLE;
      msp_cmd_frame = 1'b0;
      msp_len       = 8'd0;
      msp_cnt       = 8'd0;
      msp_sum       = 8'd0;
      msp_cmd       = 8'd0;
      fw_st         = FP_IDLE;
      fw_cmd        = 8'd0;
      fw_addr       = 16'd0;
      fw_len        = 9'd0;
      fw_cnt        = 9'd0;
      fw_crc        = 16'd0;
      fw_crc_hi     = 8'd0;
      parsed_q.delete();
      outstanding_o = 0;
    end else begin
      // compare before predicting, so a stray word never meets its own prediction
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $error("result word with nothing outstanding");
          mismatches_o++;
        end else begin
          want = parsed_q.pop_front();
          mismatches_o += field_bad("consumed", want.consumed, consumed_i)
                        + field_bad("frame_valid", want.frame_valid, frame_valid_i)
                        + field_bad("check_failed", want.check_failed, check_failed_i)
                        + field_bad("protocol", want.protocol, protocol_i)
                        + field_bad("payload_strobe", want.payload_strobe, payload_strobe_i)
                        + field_bad("payload_index", want.payload_index, payload_index_i)
                        + field_bad("payload_byte", want.payload_byte, payload_byte_i)
                        + field_bad("command", want.command, command_i)
                        + field_bad("address", want.address, address_i)
                        + field_bad("payload_len", want.payload_len, payload_len_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        parse_word(opcode_i, data_byte_i, fresh);
        parsed_q.push_back(fresh);
      end
      outstanding_o = parsed_q.size();
    end
  end

endmodule

/* bench/dual_protocol_serial_deframer_test.sv */
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

// The block parses one serial byte per word, so the stimulus is mostly
// whole frames of both protocols with random content: MSP command and
// reply frames, oversize MSP size bytes, four-way frames, good and bad
// checks, and frames broken off half way. Forced mode opcodes, the unused
// opcode and stray bytes are mixed in as noise. Prediction and comparison
// live in the checker; this module only drives and judges.
module dual_protocol_serial_deframer_test;
  import dpsd_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 4;
  localparam int PHASE_WORDS     = 35;    // random words per idling phase
  localparam int HOLD_OFF_CYCLES = 200;   // long receiver hold-off
  localparam int STALL_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES    = 8;     // margin after the last owed word for strays

  // The input port is two bits wide; this code is left unused by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  opcode_i    = OP_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        consumed_o;
  logic        frame_valid_o;
  logic        check_failed_o;
  logic        protocol_o;
  logic        payload_strobe_o;
  logic [7:0]  payload_index_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  command_o;
  logic [15:0] address_o;
  logic [8:0]  payload_len_o;

  int mismatches;
  int outstanding;

  // Idling knobs, percent of cycles; set per phase by the stimulus
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_off_req   = 1'b0;
  int   words_sent     = 0;
  int   idle_cycles    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dual_protocol_serial_deframer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .consumed_o       (consumed_o),
    .frame_valid_o    (frame_valid_o),
    .check_failed_o   (check_failed_o),
    .protocol_o       (protocol_o),
    .payload_strobe_o (payload_strobe_o),
    .payload_index_o  (payload_index_o),
    .payload_byte_o   (payload_byte_o),
    .command_o        (command_o),
    .address_o        (address_o),
    .payload_len_o    (payload_len_o)
  );

  dual_protocol_serial_deframer_check i_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .consumed_i       (consumed_o),
    .frame_valid_i    (frame_valid_o),
    .check_failed_i   (check_failed_o),
    .protocol_i       (protocol_o),
    .payload_strobe_i (payload_strobe_o),
    .payload_index_i  (payload_index_o),
    .payload_byte_i   (payload_byte_o),
    .command_i        (command_o),
    .address_i        (address_o),
    .payload_len_i    (payload_len_o),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding)
  );

  // Offer one word and hold it until the block takes it. Idle gaps come
  // first, so valid is never lowered once raised for this word. Values
  // read just after the edge are still those the edge sampled.
  task automatic send_word(input logic [1:0] op, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Send the first keep bytes of a frame, or all of it when keep is negative
  task automatic send_bytes(input logic [7:0] fr[$], input int keep);
    foreach (fr[i]) begin
      if (keep < 0 || i < keep) send_word(OP_DATA, fr[i]);
    end
  endtask

  task automatic msp_frame(input bit reply, input int size, input bit corrupt, input int keep);
    logic [7:0] fr[$];
    logic [7:0] sum;
    logic [7:0] cmd;
    logic [7:0] part;
    cmd = 8'($urandom_range(255));
    fr.push_back(CH_DOLLAR);
    fr.push_back(CH_M);
    fr.push_back(reply ? CH_GT : CH_LT);
    fr.push_back(8'(size));
    // an oversize frame ends at its size byte; leave the rest out
    if (size <= MSP_BUF_BYTES) begin
      sum = 8'(size) ^ cmd;
      fr.push_back(cmd);
      repeat (size) begin
        part = 8'($urandom_range(255));
        sum ^= part;
        fr.push_back(part);
      end
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      fr.push_back(sum);
    end
    send_bytes(fr, keep);
  endtask

  task automatic fw_frame(input logic [7:0] len_code, input bit corrupt, input int keep);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    logic [15:0] addr;
    int          n;
    addr = 16'($urandom_range(65535));
    fr.push_back(CH_SLASH);
    fr.push_back(8'($urandom_range(255)));
    fr.push_back(addr[15:8]);
    fr.push_back(addr[7:0]);
    fr.push_back(len_code);
    n = (len_code == 8'd0) ? 256 : int'(len_code);
    repeat (n) fr.push_back(8'($urandom_range(255)));
    crc = 16'h0000;
    foreach (fr[i]) crc = crc_step(crc, fr[i]);
    if (corrupt) crc ^= 16'($urandom_range(1, 65535));
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
    send_bytes(fr, keep);
  endtask

  // One random chunk: mostly whole frames, then broken frames and noise
  task automatic random_chunk();
    int pick;
    int size;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(1)) send_word(OP_FORCE_MSP, 8'($urandom_range(255)));
      size = ($urandom_range(9) == 0) ? $urandom_range(193, 255) : $urandom_range(0, 6);
      msp_frame($urandom_range(4) == 0, size, $urandom_range(4) == 0, -1);
    end else if (pick < 75) begin
      if ($urandom_range(1)) send_word(OP_FORCE_FW, 8'($urandom_range(255)));
      fw_frame(8'($urandom_range(1, 6)), $urandom_range(4) == 0, -1);
    end else if (pick < 87) begin
      if ($urandom_range(1)) msp_frame(1'b0, $urandom_range(0, 6), 1'b0, $urandom_range(1, 6));
      else fw_frame(8'($urandom_range(1, 6)), 1'b0, $urandom_range(1, 7));
    end else begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // Receiver: random stalls per phase, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[dual_protocol_serial_deframer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int idle_pcts[4];
    int stall_pcts[4];
    int phase_start;
    idle_pcts  = '{0, 74, 0, 9};
    stall_pcts = '{0, 0, 74, 9};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a stray byte while idle, the unused opcode
    send_word(OP_DATA, 8'h00);
    send_word(OP_UNUSED, 8'hFF);
    // good MSP command frame: size 1, command 0xFF, payload 0x00
    send_word(OP_DATA, CH_DOLLAR);
    send_word(OP_DATA, CH_M);
    send_word(OP_DATA, CH_LT);
    send_word(OP_DATA, 8'h01);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'hFE);
    // good MSP reply frame, empty payload: parsed and dropped silently
    send_word(OP_DATA, CH_DOLLAR);
    send_word(OP_DATA, CH_M);
    send_word(OP_DATA, CH_GT);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'h10);
    send_word(OP_DATA, 8'h10);
    // oversize size byte: drop the frame
    send_word(OP_DATA, CH_DOLLAR);
    send_word(OP_DATA, CH_M);
    send_word(OP_DATA, CH_LT);
    send_word(OP_DATA, MSP_BUF_BYTES + 8'd1);
    // four-way frame with forced mode changes inside it and a bad CRC
    send_word(OP_DATA, CH_SLASH);
    send_word(OP_DATA, 8'hA5);
    send_word(OP_FORCE_MSP, 8'hFF);
    send_word(OP_FORCE_FW, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'h01);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'h00);

    // Both parsers are idle now: the longest frames of each protocol, with
    // the receiver held off meanwhile so that the block fills and stalls
    hold_off_req = 1'b1;
    fw_frame(8'h00, 1'b0, -1);
    msp_frame(1'b0, MSP_BUF_BYTES, 1'b0, -1);

    // Random phases under the different idling mixes
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      phase_start    = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) random_chunk();
    end

    // Drain: wait for every owed word, then the drain margin for strays
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[dual_protocol_serial_deframer] OK");
    end else begin
      $display("[dual_protocol_serial_deframer] ERROR");
    end
    $finish;
  end

endmodule
